@@ hw/rtl/assert_macros.svh @@
// Assertion macros shared by the line to quad RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Plain property check on the rising clock, off while reset is low.
`define LQV_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Same-cycle implication check.
`define LQV_ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

`endif

@@ hw/rtl/lqv_pkg.sv @@
// Package: shared constants for the line to quad corner pipeline.
package lqv_pkg;
	// default coordinate width (signed Q16.16)
	localparam int COORD_WIDTH_DEF = 32;
	// normalized magnitude width: max(|dx|,|dy|) sits in [2^30, 2^31)
	localparam int NORM_W = 31;
	// radicand and root of the length square root
	localparam int RAD_W = 64;
	localparam int SQRT_W = 32;
	localparam int SQRT_STEPS = RAD_W / 2;
	// partial remainder width of the sqrt and divide cells
	localparam int REM_W = 34;
endpackage

@@ hw/rtl/lqv_if.sv @@
// Interfaces: segment input channel and quad corner output channel.
interface lqv_in_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] start_x;
	logic signed [CW-1:0] start_y;
	logic signed [CW-1:0] end_x;
	logic signed [CW-1:0] end_y;
	logic [CW-2:0] line_width;
	modport source(output valid, start_x, start_y, end_x, end_y, line_width, input ready);
	modport sink(input valid, start_x, start_y, end_x, end_y, line_width, output ready);
endinterface

interface lqv_out_if #(parameter int CW = 32);
	logic valid;
	logic ready;
	logic signed [CW-1:0] corner0_x;
	logic signed [CW-1:0] corner0_y;
	logic signed [CW-1:0] corner1_x;
	logic signed [CW-1:0] corner1_y;
	logic signed [CW-1:0] corner2_x;
	logic signed [CW-1:0] corner2_y;
	logic signed [CW-1:0] corner3_x;
	logic signed [CW-1:0] corner3_y;
	logic degenerate;
	modport source(output valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
		corner2_y, corner3_x, corner3_y, degenerate, input ready);
	modport sink(input valid, corner0_x, corner0_y, corner1_x, corner1_y, corner2_x,
		corner2_y, corner3_x, corner3_y, degenerate, output ready);
endinterface

@@ hw/rtl/lqv_norm.sv @@
// Two-stage normalizer: abs of the deltas, then scale max magnitude into [2^30, 2^31).
module lqv_norm #(
	parameter int DW = 33,
	parameter int SIDE_W = 8
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            en,
	input  logic                            vld_i,
	input  logic signed [DW-1:0]            dx_i,
	input  logic signed [DW-1:0]            dy_i,
	input  logic [SIDE_W-1:0]               side_i,
	output logic                            vld_o,
	output logic [lqv_pkg::NORM_W-1:0]      ax_o,
	output logic [lqv_pkg::NORM_W-1:0]      ay_o,
	output logic                            dx_neg_o,
	output logic                            dy_pos_o,
	output logic [SIDE_W-1:0]               side_o
);
	import lqv_pkg::*;

	localparam int MW = DW - 1;
	localparam int XW = (MW > NORM_W) ? MW : NORM_W;

	logic [XW-1:0] xr, yr, x_s1, y_s1, xl, yl;
	logic [DW-1:0] negx, negy;
	logic dx_neg_s1, dy_pos_s1, vld_s1;
	logic [SIDE_W-1:0] side_s1;

	// stage 1: magnitudes, then right shifts by 32,16,8,4,2,1 while too large
	always_comb begin
		logic [XW-1:0] o;
		int k;
		negx = -dx_i;
		negy = -dy_i;
		xr = dx_i[DW-1] ? XW'(negx) : XW'(dx_i);
		yr = dy_i[DW-1] ? XW'(negy) : XW'(dy_i);
		for (int i = 0; i < 6; i++) begin
			k = 32 >> i;
			o = xr | yr;
			// shift when at least k bits sit above the normalized width
			if ((o >> (NORM_W + k - 1)) != '0) begin
				xr = xr >> k;
				yr = yr >> k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s1 <= xr;
			y_s1 <= yr;
			dx_neg_s1 <= dx_i[DW-1];
			dy_pos_s1 <= !dy_i[DW-1] && (dy_i != '0);
			side_s1 <= side_i;
		end
	end

	// stage 2: left shifts by 16,8,4,2,1 while too small
	always_comb begin
		logic [XW-1:0] o;
		int k;
		xl = x_s1;
		yl = y_s1;
		for (int i = 0; i < 5; i++) begin
			k = 16 >> i;
			o = xl | yl;
			if ((o >> (NORM_W - k)) == '0) begin
				xl = xl << k;
				yl = yl << k;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ax_o <= xl[NORM_W-1:0];
			ay_o <= yl[NORM_W-1:0];
			dx_neg_o <= dx_neg_s1;
			dy_pos_o <= dy_pos_s1;
			side_o <= side_s1;
		end
	end
endmodule

@@ hw/rtl/lqv_sqrt_cell.sv @@
// Square root cell: one root digit (two radicand bits) per stage.
module lqv_sqrt_cell #(
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_i,
	input  logic [lqv_pkg::RAD_W-1:0]    rad_i,
	input  logic [lqv_pkg::REM_W-1:0]    rem_i,
	input  logic [lqv_pkg::SQRT_W-1:0]   root_i,
	input  logic [SIDE_W-1:0]            side_i,
	output logic                         vld_o,
	output logic [lqv_pkg::RAD_W-1:0]    rad_o,
	output logic [lqv_pkg::REM_W-1:0]    rem_o,
	output logic [lqv_pkg::SQRT_W-1:0]   root_o,
	output logic [SIDE_W-1:0]            side_o
);
	import lqv_pkg::*;

	logic [REM_W-1:0] rem_n, trial;
	logic take;

	// bring down two bits, try (root*4 + 1)
	assign rem_n = {rem_i[REM_W-3:0], rad_i[RAD_W-1:RAD_W-2]};
	assign trial = {REM_W'(root_i) << 2} | REM_W'(1);
	assign take = rem_n >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rad_o <= rad_i << 2;
			rem_o <= take ? rem_n - trial : rem_n;
			root_o <= {root_i[SQRT_W-2:0], take};
			side_o <= side_i;
		end
	end
endmodule

@@ hw/rtl/lqv_div_cell.sv @@
// Divide cell: one quotient bit per stage for both offset lanes, shared divisor.
module lqv_div_cell #(
	parameter int NUM_W = 64,
	parameter int QW = 32,
	parameter int SIDE_W = 8
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         en,
	input  logic                         vld_i,
	input  logic [lqv_pkg::SQRT_W:0]     d_i,
	input  logic [NUM_W-1:0]             num_a_i,
	input  logic [NUM_W-1:0]             num_b_i,
	input  logic [lqv_pkg::REM_W-1:0]    rem_a_i,
	input  logic [lqv_pkg::REM_W-1:0]    rem_b_i,
	input  logic [QW-1:0]                q_a_i,
	input  logic [QW-1:0]                q_b_i,
	input  logic [SIDE_W-1:0]            side_i,
	output logic                         vld_o,
	output logic [lqv_pkg::SQRT_W:0]     d_o,
	output logic [NUM_W-1:0]             num_a_o,
	output logic [NUM_W-1:0]             num_b_o,
	output logic [lqv_pkg::REM_W-1:0]    rem_a_o,
	output logic [lqv_pkg::REM_W-1:0]    rem_b_o,
	output logic [QW-1:0]                q_a_o,
	output logic [QW-1:0]                q_b_o,
	output logic [SIDE_W-1:0]            side_o
);
	import lqv_pkg::*;

	logic [REM_W-1:0] ra, rb, dd;
	logic ta, tb;

	// shift in next dividend bit, subtract divisor when it fits
	assign dd = REM_W'(d_i);
	assign ra = {rem_a_i[REM_W-2:0], num_a_i[NUM_W-1]};
	assign rb = {rem_b_i[REM_W-2:0], num_b_i[NUM_W-1]};
	assign ta = ra >= dd;
	assign tb = rb >= dd;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_o <= 1'b0;
		end else if (en) begin
			vld_o <= vld_i;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			d_o <= d_i;
			num_a_o <= num_a_i << 1;
			num_b_o <= num_b_i << 1;
			rem_a_o <= ta ? ra - dd : ra;
			rem_b_o <= tb ? rb - dd : rb;
			q_a_o <= {q_a_i[QW-2:0], ta};
			q_b_o <= {q_b_i[QW-2:0], tb};
			side_o <= side_i;
		end
	end
endmodule

@@ hw/rtl/line_to_quad_vertices_core.sv @@
// Top level: thick line segment to quad corners, fully pipelined.
// Accepts one segment word per clock while the output is not stalled and returns one
// corner word per segment, in order. The stages are delta and normalize, squares and sum, a
// 32-cell square root chain, the offset products and dividend, a COORD_WIDTH-cell
// restoring divide chain that yields both offset magnitudes, and the corner register.
// The whole pipe advances when the output register is empty or being taken; a stalled
// output holds every stage. Coincident end points give a zero offset and raise degenerate.
`include "assert_macros.svh"

module line_to_quad_vertices_core #(
	parameter int COORD_WIDTH = lqv_pkg::COORD_WIDTH_DEF
) (
	input logic      clk,
	input logic      arst_n,
	lqv_in_if.sink   in_ch,
	lqv_out_if.source out_ch
);
	import lqv_pkg::*;

	localparam int CW = COORD_WIDTH;
	localparam int W_W = CW - 1;
	localparam int LO_W = W_W / 2;
	localparam int HI_W = W_W - LO_W;
	localparam int NUM_W = CW + 32;
	localparam int COR_W = 4 * CW;
	// side word: {start_x, start_y, end_x, end_y, width, degenerate}
	localparam int SA_W = COR_W + W_W + 1;
	// sqrt side: {ax, ay, dx_neg, dy_pos, side word}
	localparam int SB_W = 2 * NORM_W + 2 + SA_W;
	// divide side: {dx_neg, dy_pos, coords, degenerate}
	localparam int SC_W = 2 + COR_W + 1;
	localparam int D_W = SQRT_W + 1;

	logic en;
	logic out_vld_q;

	assign en = !out_vld_q || out_ch.ready;
	assign in_ch.ready = en;

	// stage 1: deltas
	logic vld_s1;
	logic signed [CW:0] dx_s1, dy_s1;
	logic [SA_W-1:0] side_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1 <= (CW+1)'(in_ch.end_x) - (CW+1)'(in_ch.start_x);
			dy_s1 <= (CW+1)'(in_ch.end_y) - (CW+1)'(in_ch.start_y);
			side_s1 <= {in_ch.start_x, in_ch.start_y, in_ch.end_x, in_ch.end_y,
				in_ch.line_width,
				(in_ch.start_x == in_ch.end_x) && (in_ch.start_y == in_ch.end_y)};
		end
	end

	// normalize
	logic vld_n, dx_neg_n, dy_pos_n;
	logic [NORM_W-1:0] ax_n, ay_n;
	logic [SA_W-1:0] side_n;

	lqv_norm #(.DW(CW + 1), .SIDE_W(SA_W)) u_norm (
		.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_s1),
		.dx_i(dx_s1), .dy_i(dy_s1), .side_i(side_s1),
		.vld_o(vld_n), .ax_o(ax_n), .ay_o(ay_n),
		.dx_neg_o(dx_neg_n), .dy_pos_o(dy_pos_n), .side_o(side_n)
	);

	// stage 4: squares; stage 5: radicand
	logic vld_s4, vld_s5;
	logic [2*NORM_W-1:0] sqx_s4, sqy_s4;
	logic [SB_W-1:0] side_s4, side_s5;
	logic [RAD_W-1:0] rad_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
			vld_s5 <= 1'b0;
		end else if (en) begin
			vld_s4 <= vld_n;
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sqx_s4 <= (2*NORM_W)'(ax_n) * (2*NORM_W)'(ax_n);
			sqy_s4 <= (2*NORM_W)'(ay_n) * (2*NORM_W)'(ay_n);
			side_s4 <= {ax_n, ay_n, dx_neg_n, dy_pos_n, side_n};
			rad_s5 <= RAD_W'(sqx_s4) + RAD_W'(sqy_s4);
			side_s5 <= side_s4;
		end
	end

	// square root chain
	logic vld_r [SQRT_STEPS+1];
	logic [RAD_W-1:0] rad_r [SQRT_STEPS+1];
	logic [REM_W-1:0] rem_r [SQRT_STEPS+1];
	logic [SQRT_W-1:0] root_r [SQRT_STEPS+1];
	logic [SB_W-1:0] side_r [SQRT_STEPS+1];

	assign vld_r[0] = vld_s5;
	assign rad_r[0] = rad_s5;
	assign rem_r[0] = '0;
	assign root_r[0] = '0;
	assign side_r[0] = side_s5;

	for (genvar g = 0; g < SQRT_STEPS; g++) begin : g_sqrt
		lqv_sqrt_cell #(.SIDE_W(SB_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_r[g]),
			.rad_i(rad_r[g]), .rem_i(rem_r[g]), .root_i(root_r[g]), .side_i(side_r[g]),
			.vld_o(vld_r[g+1]), .rad_o(rad_r[g+1]), .rem_o(rem_r[g+1]),
			.root_o(root_r[g+1]), .side_o(side_r[g+1])
		);
	end

	// unpack sqrt output
	logic [SQRT_W-1:0] len;
	logic [SB_W-1:0] sb;
	logic [NORM_W-1:0] ax_r, ay_r;
	logic [SA_W-1:0] sa_r;
	logic [W_W-1:0] w_r;
	logic [LO_W-1:0] w_lo;
	logic [HI_W-1:0] w_hi;

	assign len = root_r[SQRT_STEPS];
	assign sb = side_r[SQRT_STEPS];
	assign ax_r = sb[SB_W-1 -: NORM_W];
	assign ay_r = sb[SB_W-1-NORM_W -: NORM_W];
	assign sa_r = sb[SA_W-1:0];
	assign w_r = sa_r[W_W:1];
	assign w_lo = w_r[LO_W-1:0];
	assign w_hi = w_r[W_W-1:LO_W];

	// stage 6: partial products (x offset uses ay, y offset uses ax)
	localparam int PL_W = LO_W + NORM_W;
	localparam int PH_W = HI_W + NORM_W;
	logic vld_s6, vld_s7;
	logic [PL_W-1:0] plx_s6, ply_s6;
	logic [PH_W-1:0] phx_s6, phy_s6;
	logic [SQRT_W-1:0] len_s6;
	logic [SC_W-1:0] side_s6, side_s7;
	logic [NUM_W-1:0] numx_s7, numy_s7;
	logic [D_W-1:0] d_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
			vld_s7 <= 1'b0;
		end else if (en) begin
			vld_s6 <= vld_r[SQRT_STEPS];
			vld_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plx_s6 <= PL_W'(w_lo) * PL_W'(ay_r);
			phx_s6 <= PH_W'(w_hi) * PH_W'(ay_r);
			ply_s6 <= PL_W'(w_lo) * PL_W'(ax_r);
			phy_s6 <= PH_W'(w_hi) * PH_W'(ax_r);
			len_s6 <= len;
			side_s6 <= {sb[SA_W+1:SA_W], sa_r[SA_W-1:W_W+1], sa_r[0]};
			// dividend w*a + len, pre-aligned so the chain sees the low CW bits
			numx_s7 <= ((NUM_W'(phx_s6) << LO_W) + NUM_W'(plx_s6) + NUM_W'(len_s6));
			numy_s7 <= ((NUM_W'(phy_s6) << LO_W) + NUM_W'(ply_s6) + NUM_W'(len_s6));
			d_s7 <= {len_s6, 1'b0};
			side_s7 <= side_s6;
		end
	end

	// divide chain
	logic vld_d [CW+1];
	logic [D_W-1:0] d_d [CW+1];
	logic [NUM_W-1:0] na_d [CW+1];
	logic [NUM_W-1:0] nb_d [CW+1];
	logic [REM_W-1:0] ra_d [CW+1];
	logic [REM_W-1:0] rb_d [CW+1];
	logic [CW-1:0] qa_d [CW+1];
	logic [CW-1:0] qb_d [CW+1];
	logic [SC_W-1:0] side_d [CW+1];

	assign vld_d[0] = vld_s7;
	assign d_d[0] = d_s7;
	assign na_d[0] = numx_s7 << CW;
	assign nb_d[0] = numy_s7 << CW;
	assign ra_d[0] = REM_W'(numx_s7[NUM_W-1:CW]);
	assign rb_d[0] = REM_W'(numy_s7[NUM_W-1:CW]);
	assign qa_d[0] = '0;
	assign qb_d[0] = '0;
	assign side_d[0] = side_s7;

	for (genvar g = 0; g < CW; g++) begin : g_div
		lqv_div_cell #(.NUM_W(NUM_W), .QW(CW), .SIDE_W(SC_W)) u_cell (
			.clk(clk), .arst_n(arst_n), .en(en), .vld_i(vld_d[g]), .d_i(d_d[g]),
			.num_a_i(na_d[g]), .num_b_i(nb_d[g]), .rem_a_i(ra_d[g]), .rem_b_i(rb_d[g]),
			.q_a_i(qa_d[g]), .q_b_i(qb_d[g]), .side_i(side_d[g]),
			.vld_o(vld_d[g+1]), .d_o(d_d[g+1]), .num_a_o(na_d[g+1]), .num_b_o(nb_d[g+1]),
			.rem_a_o(ra_d[g+1]), .rem_b_o(rb_d[g+1]), .q_a_o(qa_d[g+1]),
			.q_b_o(qb_d[g+1]), .side_o(side_d[g+1])
		);
	end

	// clamp to the signed coordinate range
	function automatic logic [CW-1:0] sat(input logic [CW+1:0] v);
		logic [CW-1:0] r;
		if ((v[CW+1:CW-1] == 3'b000) || (v[CW+1:CW-1] == 3'b111)) begin
			r = v[CW-1:0];
		end else if (!v[CW+1]) begin
			r = {1'b0, {(CW-1){1'b1}}};
		end else begin
			r = {1'b1, {(CW-1){1'b0}}};
		end
		return r;
	endfunction

	// signed offsets and corners
	logic [SC_W-1:0] sc;
	logic dx_neg_f, dy_pos_f, degen_f;
	logic [CW+1:0] mx, my, nx, ny, sx, sy, ex, ey;

	assign sc = side_d[CW];
	assign dx_neg_f = sc[SC_W-1];
	assign dy_pos_f = sc[SC_W-2];
	assign degen_f = sc[0];
	assign sx = {{2{sc[4*CW]}}, sc[4*CW -: CW]};
	assign sy = {{2{sc[3*CW]}}, sc[3*CW -: CW]};
	assign ex = {{2{sc[2*CW]}}, sc[2*CW -: CW]};
	assign ey = {{2{sc[CW]}}, sc[CW -: CW]};
	assign mx = {2'b00, qa_d[CW]};
	assign my = {2'b00, qb_d[CW]};
	assign nx = degen_f ? '0 : (dy_pos_f ? -mx : mx);
	assign ny = degen_f ? '0 : (dx_neg_f ? -my : my);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (en) begin
			out_vld_q <= vld_d[CW];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			out_ch.corner0_x <= sat(sx + nx);
			out_ch.corner0_y <= sat(sy + ny);
			out_ch.corner1_x <= sat(sx - nx);
			out_ch.corner1_y <= sat(sy - ny);
			out_ch.corner2_x <= sat(ex - nx);
			out_ch.corner2_y <= sat(ey - ny);
			out_ch.corner3_x <= sat(ex + nx);
			out_ch.corner3_y <= sat(ey + ny);
			out_ch.degenerate <= degen_f;
		end
	end

	assign out_ch.valid = out_vld_q;

	// checks
	`LQV_ASSERT_IMP(a_norm_range, clk, arst_n, vld_n && !side_n[0], ax_n[NORM_W-1] || ay_n[NORM_W-1], "normalized magnitude below range")
	`LQV_ASSERT_IMP(a_len_range, clk, arst_n, vld_r[SQRT_STEPS] && !sb[0], len[SQRT_W-1] || len[SQRT_W-2], "segment length below range")
	`LQV_ASSERT(a_degen_corners, clk, arst_n, !(out_ch.valid && out_ch.degenerate) || ((out_ch.corner0_x == out_ch.corner1_x) && (out_ch.corner0_y == out_ch.corner1_y) && (out_ch.corner2_x == out_ch.corner3_x)), "degenerate word with nonzero offset")
endmodule

@@ sim/line_to_quad_vertices_core_tb.sv @@
// Testbench for the line to quad corner pipeline: directed and random segments, scoreboarded.
module line_to_quad_vertices_core_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = 32;
	localparam int LATENCY = CW + 40;

	typedef struct packed {
		logic signed [CW-1:0] sx, sy, ex, ey;
		logic [CW-2:0] w;
	} segment_t;

	typedef struct packed {
		logic signed [CW-1:0] c0x, c0y, c1x, c1y, c2x, c2y, c3x, c3y;
		logic degen;
	} quad_t;

	logic clk;
	logic arst_n;
	lqv_in_if #(.CW(CW)) seg_ch();
	lqv_out_if #(.CW(CW)) quad_ch();

	line_to_quad_vertices_core #(.COORD_WIDTH(CW)) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(seg_ch.sink),
		.out_ch(quad_ch.source)
	);

	segment_t pending_segs[$];
	quad_t expected_quads[$];
	int errors = 0;
	int quads_seen = 0;
	int degen_seen = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_recv = 0;
	bit gate_send = 0;

	// floor(sqrt(v)), bit by bit
	function automatic logic [63:0] root64(logic [63:0] v);
		logic [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > v)
			b >>= 2;
		while (b != 0) begin
			if (v >= r + b) begin
				v -= r + b;
				r = (r >> 1) + b;
			end else begin
				r >>= 1;
			end
			b >>= 2;
		end
		return r;
	endfunction

	function automatic logic signed [CW-1:0] clamp(logic signed [65:0] v);
		if (v > 66'sh7FFFFFFF)
			return 32'sh7FFFFFFF;
		if (v < -66'sh80000000)
			return 32'sh80000000;
		return v[CW-1:0];
	endfunction

	// quad corners of one segment: quarter-turned unit direction times half width
	function automatic quad_t quad_of(segment_t s);
		quad_t q;
		logic signed [65:0] dx, dy, nx, ny;
		logic [63:0] ax, ay, len;
		logic [127:0] mx, my;
		dx = $signed(s.ex) - $signed(s.sx);
		dy = $signed(s.ey) - $signed(s.sy);
		nx = 0;
		ny = 0;
		q.degen = (dx == 0 && dy == 0);
		if (!q.degen) begin
			ax = dx < 0 ? 64'(-dx) : 64'(dx);
			ay = dy < 0 ? 64'(-dy) : 64'(dy);
			while ((ax > ay ? ax : ay) < (64'd1 << 30)) begin
				ax <<= 1;
				ay <<= 1;
			end
			while ((ax > ay ? ax : ay) >= (64'd1 << 31)) begin
				ax >>= 1;
				ay >>= 1;
			end
			len = root64(ax * ax + ay * ay);
			mx = (128'(s.w) * ay + len) / (128'(len) << 1);
			my = (128'(s.w) * ax + len) / (128'(len) << 1);
			nx = dy > 0 ? -$signed(66'(mx)) : $signed(66'(mx));
			ny = dx < 0 ? -$signed(66'(my)) : $signed(66'(my));
		end
		q.c0x = clamp($signed(s.sx) + nx);
		q.c0y = clamp($signed(s.sy) + ny);
		q.c1x = clamp($signed(s.sx) - nx);
		q.c1y = clamp($signed(s.sy) - ny);
		q.c2x = clamp($signed(s.ex) - nx);
		q.c2y = clamp($signed(s.ey) - ny);
		q.c3x = clamp($signed(s.ex) + nx);
		q.c3y = clamp($signed(s.ey) + ny);
		return q;
	endfunction

	initial begin
		clk = 0;
		forever #4 clk = ~clk;
	end

	// driver: offers the next queued segment word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seg_ch.valid <= 0;
			seg_ch.start_x <= 0;
			seg_ch.start_y <= 0;
			seg_ch.end_x <= 0;
			seg_ch.end_y <= 0;
			seg_ch.line_width <= 0;
		end else if (!seg_ch.valid || seg_ch.ready) begin
			if (seg_ch.valid)
				expected_quads.push_back(quad_of({seg_ch.start_x, seg_ch.start_y,
					seg_ch.end_x, seg_ch.end_y, seg_ch.line_width}));
			if (pending_segs.size() > 0 && !gate_send &&
					$urandom_range(99) >= send_idle_pct) begin
				segment_t s;
				s = pending_segs.pop_front();
				seg_ch.valid <= 1;
				seg_ch.start_x <= s.sx;
				seg_ch.start_y <= s.sy;
				seg_ch.end_x <= s.ex;
				seg_ch.end_y <= s.ey;
				seg_ch.line_width <= s.w;
			end else begin
				seg_ch.valid <= 0;
			end
		end
	end

	// receiver backpressure, with a counted long hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quad_ch.ready <= 0;
		end else if (hold_recv > 0) begin
			hold_recv <= hold_recv - 1;
			quad_ch.ready <= 0;
		end else begin
			quad_ch.ready <= $urandom_range(99) >= recv_stall_pct;
		end
	end

	// monitor: compares each corner word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && quad_ch.valid && quad_ch.ready) begin
			quad_t got, want;
			got = {quad_ch.corner0_x, quad_ch.corner0_y, quad_ch.corner1_x,
				quad_ch.corner1_y, quad_ch.corner2_x, quad_ch.corner2_y,
				quad_ch.corner3_x, quad_ch.corner3_y, quad_ch.degenerate};
			if (expected_quads.size() == 0) begin
				$error("corner word with nothing expected");
				errors++;
			end else begin
				want = expected_quads.pop_front();
				quads_seen++;
				if (want.degen)
					degen_seen++;
				if (got.c0x !== want.c0x) begin
					$error("corner0_x exp %0d got %0d", want.c0x, got.c0x); errors++;
				end
				if (got.c0y !== want.c0y) begin
					$error("corner0_y exp %0d got %0d", want.c0y, got.c0y); errors++;
				end
				if (got.c1x !== want.c1x) begin
					$error("corner1_x exp %0d got %0d", want.c1x, got.c1x); errors++;
				end
				if (got.c1y !== want.c1y) begin
					$error("corner1_y exp %0d got %0d", want.c1y, got.c1y); errors++;
				end
				if (got.c2x !== want.c2x) begin
					$error("corner2_x exp %0d got %0d", want.c2x, got.c2x); errors++;
				end
				if (got.c2y !== want.c2y) begin
					$error("corner2_y exp %0d got %0d", want.c2y, got.c2y); errors++;
				end
				if (got.c3x !== want.c3x) begin
					$error("corner3_x exp %0d got %0d", want.c3x, got.c3x); errors++;
				end
				if (got.c3y !== want.c3y) begin
					$error("corner3_y exp %0d got %0d", want.c3y, got.c3y); errors++;
				end
				if (got.degen !== want.degen) begin
					$error("degenerate exp %0d got %0d", want.degen, got.degen); errors++;
				end
			end
		end
	end

	function automatic logic signed [CW-1:0] rand_coord();
		case ($urandom_range(5))
			0: return $urandom();
			1: return $signed($urandom_range(0, 1 << 20)) - (1 << 19);
			2: return $urandom_range(1) ? 32'sh7FFFFFFF - $urandom_range(1000) :
				32'sh80000000 + $urandom_range(1000);
			default: return $signed($urandom_range(0, 1 << 24)) - (1 << 23);
		endcase
	endfunction

	function automatic segment_t rand_seg();
		segment_t s;
		s.sx = rand_coord();
		s.sy = rand_coord();
		case ($urandom_range(9))
			0: begin s.ex = s.sx; s.ey = s.sy; end
			1: begin s.ex = s.sx + $signed($urandom_range(4)) - 2; s.ey = s.sy; end
			2: begin s.ex = s.sx; s.ey = rand_coord(); end
			default: begin s.ex = rand_coord(); s.ey = rand_coord(); end
		endcase
		case ($urandom_range(3))
			0: s.w = 31'($urandom());
			1: s.w = $urandom_range(1) ? 31'h7FFFFFFF : 31'd0;
			default: s.w = 31'($urandom_range(0, 1 << 20));
		endcase
		return s;
	endfunction

	task automatic add_seg(int sx, int sy, int ex, int ey, int w);
		pending_segs.push_back({sx[CW-1:0], sy[CW-1:0], ex[CW-1:0], ey[CW-1:0], w[CW-2:0]});
	endtask

	task automatic drain();
		wait (pending_segs.size() == 0 && !seg_ch.valid && expected_quads.size() == 0);
	endtask

	initial begin
		arst_n = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;

		// directed: axis lines, diagonals, coincident ends, extremes, saturation
		add_seg(0, 0, 32'h10000, 0, 32'h20000);
		add_seg(0, 0, 0, 32'h10000, 32'h20000);
		add_seg(0, 0, -32'h10000, 0, 32'h20000);
		add_seg(0, 0, 0, -32'h10000, 32'h20000);
		add_seg(0, 0, 32'h30000, 32'h40000, 32'ha0000);
		add_seg(5, 7, 5, 7, 32'h7FFFFFFF);
		add_seg(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 0);
		add_seg(32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
		add_seg(32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF);
		add_seg(32'h7FFFFFFF, 0, 32'h7FFFFFFF, 1, 32'h7FFFFFFF);
		add_seg(32'h80000000, 0, 32'h80000000, -1, 32'h7FFFFFFF);
		add_seg(0, 0, 1, 0, 1);
		add_seg(0, 0, 1, 1, 3);
		add_seg(-1, -1, 0, 0, 32'h7FFFFFFF);
		add_seg(32'hFFFFFFFF, 32'hAAAAAAAA, 32'h55555555, 32'h0, 32'h55555555);
		add_seg(32'h12345678, -32'h12345678, -32'h12345678, 32'h12345678, 32'h2AAAAAAA);
		drain();

		// random phases: no idling, sender idle, receiver stall, both
		for (int ph = 0; ph < 4; ph++) begin
			send_idle_pct = (ph == 1 || ph == 3) ? (ph == 1 ? 46 : 13) : 0;
			recv_stall_pct = (ph == 2 || ph == 3) ? (ph == 2 ? 46 : 13) : 0;
			for (int i = 0; i < 100; i++)
				pending_segs.push_back(rand_seg());
			if (ph == 0) begin
				// long receiver hold-off so the pipe fills and stalls its input
				@(posedge clk);
				hold_recv <= 3 * LATENCY;
			end
			drain();
		end

		// sender holds back while the segments are queued, then sends them as a final burst
		send_idle_pct = 0;
		recv_stall_pct = 0;
		gate_send = 1;
		for (int i = 0; i < 40; i++)
			pending_segs.push_back(rand_seg());
		repeat (20) @(posedge clk);
		gate_send = 0;
		drain();
		repeat (LATENCY + 10) @(posedge clk);

		$display("Checked %0d quads (%0d with coincident end points) across four idling phases",
			quads_seen, degen_seen);
		$display("including a long output stall and a full pipeline drain.");
		if (errors == 0 && expected_quads.size() == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	initial begin
		#2ms;
		$display("simulation failed");
		$finish;
	end
endmodule
